### rtl/first_fit_heap_allocator_macros.svh
// Assertion macros shared by the first-fit heap allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ffha_pkg.sv
// Types and constants shared by the first-fit heap allocator modules.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

  localparam int HEAP_UNITS = 4096;
  localparam int ADDR_W     = 12;
  localparam int PTR_W      = ADDR_W + 1;
  localparam int HDR_W      = ADDR_W + 1;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_DOUBLE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL_ALLOC,
    S_EVAL_FREE,
    S_SPLIT_WR,
    S_RESULT
  } state_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [ADDR_W-1:0]   size;
    logic [ADDR_W-1:0]   addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    status_t             status;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: request intake and result register.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ----------------------------------------
//   in        in_valid / in_stall    opcode, request_size, block_address
//   out       out_valid / out_stall  result_address, status
//
// After reset the header store is swept to zero, one entry per cycle, across
// all 4096 entries; in_stall stays high throughout that sweep.
// A free reads the header in front of its block, then clears its flag or
// reports a double free. An allocate walks the header chain from the heap
// base, reading one header at a time through the single read port of the
// header store, and writes one more header when a free block is split.
// One request is in work at a time: in_stall drops in the cycle after the
// result is handed to the output register, so the next request transfer may
// be taken while out_stall holds that result.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [ffha_pkg::ADDR_W-1:0] request_size,
  input  logic [ffha_pkg::ADDR_W-1:0] block_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ffha_pkg::ADDR_W-1:0] result_address,
  output logic [1:0]                  status
);

  import ffha_pkg::*;

  req_t req;
  rsp_t rsp;
  logic req_ready;
  logic rsp_valid;
  logic rsp_take;

  // The request is handed straight to the sequencer, which captures what it
  // needs in the cycle of the transfer.
  always_comb begin
    req.opcode = opcode_t'(opcode);
    req.size   = request_size;
    req.addr   = block_address;
  end

  assign in_stall = !req_ready;

  // The output register may take a new result when it is empty or when its
  // current content leaves in this cycle.
  assign rsp_take = !out_valid || !out_stall;

  ffha_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req       (req),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_take  (rsp_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_valid && rsp_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (rsp_valid && rsp_take) begin
      result_address <= rsp.addr;
      status         <= rsp.status;
    end
  end

endmodule

`default_nettype wire

### rtl/ffha_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/ffha_walker.sv
// Header store, clearing pass and the sequencer that walks the header chain.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_heap_allocator_macros.svh"

module ffha_walker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  ffha_pkg::req_t req,
  output logic          req_ready,
  output logic          rsp_valid,
  output ffha_pkg::rsp_t rsp,
  input  logic          rsp_take
);

  import ffha_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] clr_cnt_next;
  logic [ADDR_W-1:0] p;
  logic [ADDR_W-1:0] p_next;
  logic [ADDR_W-1:0] want;
  logic [ADDR_W-1:0] want_next;
  logic              free_zero;
  logic              free_zero_next;
  logic [ADDR_W-1:0] split_addr;
  logic [ADDR_W-1:0] split_addr_next;
  logic [ADDR_W-1:0] split_size;
  logic [ADDR_W-1:0] split_size_next;
  logic [ADDR_W-1:0] res_addr;
  logic [ADDR_W-1:0] res_addr_next;
  status_t           res_status;
  status_t           res_status_next;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [HDR_W-1:0]  wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [HDR_W-1:0]  rd_data;

  logic              hdr_flag;
  logic [ADDR_W-1:0] hdr_size;
  logic [PTR_W-1:0]  walk_next;
  logic [PTR_W-1:0]  append_end;
  logic              walk_off;
  logic              append_fail;
  logic              is_frontier;
  logic              fits;
  logic              stepping;
  logic [ADDR_W-1:0] surplus;
  logic              do_split;

  ffha_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HEAP_UNITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Decode of the header that the previous cycle fetched.
  always_comb begin
    hdr_flag    = rd_data[HDR_W-1];
    hdr_size    = rd_data[ADDR_W-1:0];
    walk_next   = PTR_W'(p) + PTR_W'(hdr_size) + PTR_W'(1);
    append_end  = PTR_W'(p) + PTR_W'(want) + PTR_W'(1);
    walk_off    = walk_next >= PTR_W'(HEAP_UNITS);
    append_fail = append_end > PTR_W'(HEAP_UNITS);
    is_frontier = !hdr_flag && (hdr_size == '0);
    fits        = !hdr_flag && (hdr_size != '0) && (hdr_size >= want);
    stepping    = hdr_flag || (!is_frontier && !fits);
    surplus     = hdr_size - want;
    do_split    = surplus >= ADDR_W'(2);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == ADDR_W'(HEAP_UNITS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req.opcode == OP_FREE) ? S_EVAL_FREE : S_EVAL_ALLOC;
        end
      end
      S_EVAL_ALLOC: begin
        if (stepping) begin
          state_next = walk_off ? S_RESULT : S_EVAL_ALLOC;
        end else if (fits && do_split) begin
          state_next = S_SPLIT_WR;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_EVAL_FREE: begin
        state_next = S_RESULT;
      end
      S_SPLIT_WR: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (rsp_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = p;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = p;
    clr_cnt_next    = clr_cnt;
    p_next          = p;
    want_next       = want;
    free_zero_next  = free_zero;
    split_addr_next = split_addr;
    split_size_next = split_size;
    res_addr_next   = res_addr;
    res_status_next = res_status;
    req_ready       = 1'b0;
    rsp_valid       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_cnt;
        clr_cnt_next = clr_cnt + ADDR_W'(1);
      end
      S_IDLE: begin
        req_ready       = 1'b1;
        res_addr_next   = '0;
        res_status_next = ST_OK;
        if (req_valid) begin
          rd_en = 1'b1;
          if (req.opcode == OP_FREE) begin
            rd_addr        = req.addr - ADDR_W'(1);
            p_next         = req.addr - ADDR_W'(1);
            free_zero_next = req.addr == '0;
          end else begin
            rd_addr   = '0;
            p_next    = '0;
            want_next = (req.size == '0) ? ADDR_W'(1) : req.size;
          end
        end
      end
      S_EVAL_ALLOC: begin
        if (stepping) begin
          if (walk_off) begin
            res_status_next = ST_OOM;
          end else begin
            rd_en   = 1'b1;
            rd_addr = walk_next[ADDR_W-1:0];
            p_next  = walk_next[ADDR_W-1:0];
          end
        end else if (is_frontier) begin
          if (append_fail) begin
            res_status_next = ST_OOM;
          end else begin
            wr_en         = 1'b1;
            wr_data       = {1'b1, want};
            res_addr_next = p + ADDR_W'(1);
          end
        end else begin
          wr_en         = 1'b1;
          res_addr_next = p + ADDR_W'(1);
          if (do_split) begin
            wr_data         = {1'b1, want};
            split_addr_next = append_end[ADDR_W-1:0];
            split_size_next = surplus - ADDR_W'(1);
          end else begin
            wr_data = {1'b1, hdr_size};
          end
        end
      end
      S_EVAL_FREE: begin
        if (free_zero || !hdr_flag) begin
          res_status_next = ST_DOUBLE;
        end else begin
          wr_en   = 1'b1;
          wr_data = {1'b0, hdr_size};
        end
      end
      S_SPLIT_WR: begin
        wr_en   = 1'b1;
        wr_addr = split_addr;
        wr_data = {1'b0, split_size};
      end
      S_RESULT: begin
        rsp_valid = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rsp.addr   = res_addr;
  assign rsp.status = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
    p          <= p_next;
    want       <= want_next;
    free_zero  <= free_zero_next;
    split_addr <= split_addr_next;
    split_size <= split_size_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
  end

  `FFHA_ASSERT_NOW(a_no_write_idle, state == S_IDLE, !wr_en, "header written while idle")
  `FFHA_ASSERT_NOW(a_no_take_clear, state == S_CLEAR, !req_ready, "request taken during clear")
  `FFHA_ASSERT_NEXT(a_take_to_eval, (state == S_IDLE) && req_valid, (state == S_EVAL_ALLOC) || (state == S_EVAL_FREE), "request not evaluated")
  `FFHA_ASSERT_NEXT(a_split_apart, (state == S_EVAL_ALLOC) && (state_next == S_SPLIT_WR), wr_en && (wr_addr != $past(wr_addr)), "split header overlaps block header")
  `FFHA_ASSERT_NOW(a_fail_zero_addr, rsp_valid && (rsp.status != ST_OK), rsp.addr == '0, "failed result carries an address")

endmodule

`default_nettype wire
